FILE: rtl/pidaw_pkg.sv
// package: widths, register indexes, defaults and saturation helper for the pid core
`default_nettype none

package pidaw_pkg;

  // parameter defaults
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 24;

  // fixed field widths
  localparam int GAIN_W  = 16;
  localparam int TICK_W  = 16;
  localparam int LIMIT_W = 23;
  localparam int OUT_W   = 48;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd4;

  // shared multiplier: 17-bit signed small operand times a 48-bit wide operand,
  // taken as a signed upper half and an unsigned lower half
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int WIDE_W  = OUT_W;
  localparam int SPLIT_W = WIDE_W / 2;
  localparam int MUL_B_W = SPLIT_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int MACC_W  = PROD_W + SPLIT_W;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MACC_W-1:0] v);
    if ((v[MACC_W-1:OUT_W-1] == '0) || (v[MACC_W-1:OUT_W-1] == '1)) begin
      return v[OUT_W-1:0];
    end else if (v[MACC_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pid_controller_anti_windup_core.sv
// pid controller with integrator clamp: sequencer, shared multiplier and serial divider
// one item in flight: a new input transaction is taken only once the previous result is loaded
//   into the output register, which waits while an earlier result is still stalled;
//   elapsed_ticks of 0 skips the integral and derivative products and the divider
// the sequence runs through the single shared 17x25 multiplier (two passes per product, up to four products)
//   and the 2-bit-per-cycle divider for the derivative term
// reset (rst, synchronous): gains, clamp, limit, integrator and previous error clear to zero
`default_nettype none

module pid_controller_anti_windup_core #(
  parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = pidaw_pkg::ACC_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   cfg_we,
  input  wire  [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [pidaw_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [SAMPLE_WIDTH-1:0]         measured,
  input  wire  signed [SAMPLE_WIDTH-1:0]         setpoint,
  input  wire  [pidaw_pkg::TICK_W-1:0]           elapsed_ticks,
  // output channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [pidaw_pkg::OUT_W-1:0]     drive,
  output logic signed [pidaw_pkg::OUT_W-1:0]     p_term,
  output logic signed [pidaw_pkg::OUT_W-1:0]     i_term,
  output logic signed [pidaw_pkg::OUT_W-1:0]     d_term
);

  // derived widths
  localparam int ERR_W     = SAMPLE_WIDTH + 1;
  localparam int DIFF_W    = SAMPLE_WIDTH + 2;
  localparam int NUM_W     = pidaw_pkg::GAIN_W + DIFF_W;
  localparam int DIV_STEPS = (NUM_W + 1) / 2;
  localparam int DIV_W     = 2 * DIV_STEPS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int BASE_W    = (ACC_WIDTH > ERR_W) ? ACC_WIDTH : ERR_W;
  localparam int BASE2_W   = (BASE_W > pidaw_pkg::LIMIT_W + 1) ? BASE_W : pidaw_pkg::LIMIT_W + 1;
  localparam int SUM_W     = BASE2_W + 1;

  localparam int OUT_W   = pidaw_pkg::OUT_W;
  localparam int WIDE_W  = pidaw_pkg::WIDE_W;
  localparam int SPLIT_W = pidaw_pkg::SPLIT_W;
  localparam int MUL_A_W = pidaw_pkg::MUL_A_W;
  localparam int MUL_B_W = pidaw_pkg::MUL_B_W;
  localparam int PROD_W  = pidaw_pkg::PROD_W;
  localparam int MACC_W  = pidaw_pkg::MACC_W;
  localparam int TICK_W  = pidaw_pkg::TICK_W;
  localparam int LIMIT_W = pidaw_pkg::LIMIT_W;
  localparam int GAIN_W  = pidaw_pkg::GAIN_W;

  // integrator saturation bounds in the wide sum format
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

  typedef enum logic [3:0] {
    S_IDLE, S_INTEG, S_CLAMP, S_MUL_HI, S_MUL_LO, S_MUL_END, S_DIV, S_DFIN, S_SUM
  } state_t;

  // product currently in the multiplier
  typedef enum logic [1:0] {
    OP_P, OP_KI, OP_TK, OP_KD
  } op_t;

  state_t state;
  op_t    op;

  // configuration registers
  logic signed [GAIN_W-1:0]  prop_gain;
  logic signed [GAIN_W-1:0]  integ_gain;
  logic signed [GAIN_W-1:0]  deriv_gain;
  logic                      clamp_enable;
  logic [LIMIT_W-1:0]        integ_limit;

  // loop state
  logic signed [ACC_WIDTH-1:0] integ_acc;
  logic signed [ERR_W-1:0]     prev_error;

  // per-item working registers
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic [TICK_W-1:0]        ticks;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [OUT_W-1:0]  p_q;
  logic signed [OUT_W-1:0]  i_q;
  logic signed [OUT_W-1:0]  d_q;
  logic signed [OUT_W-1:0]  tprod;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [WIDE_W-1:0]  mul_b;
  logic signed [MUL_B_W-1:0] mul_opnd;
  logic signed [PROD_W-1:0]  mul_out;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  macc_hi;
  logic signed [MACC_W-1:0]  fin;
  logic signed [OUT_W-1:0]   fin_sat;

  // serial divider
  logic [DIV_W-1:0]     dq;
  logic [DIV_W-1:0]     dq_next;
  logic [TICK_W-1:0]    rem;
  logic [TICK_W-1:0]    rem_next;
  logic                 div_neg;
  logic [CNT_W-1:0]     div_cnt;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]     num_mag;
  logic signed [MACC_W-1:0] quo_ext;

  // integrator clamp and saturation
  logic signed [SUM_W-1:0] lim_pos;
  logic signed [SUM_W-1:0] lim_neg;
  logic signed [SUM_W-1:0] sum_clamp;
  logic signed [SUM_W-1:0] sum_sat;

  // final sum
  logic signed [MACC_W-1:0] drive_sum;
  logic                     out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      clamp_enable <= 1'b0;
      integ_limit  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pidaw_pkg::REG_PROP_GAIN:    prop_gain    <= cfg_data[GAIN_W-1:0];
        pidaw_pkg::REG_INTEG_GAIN:   integ_gain   <= cfg_data[GAIN_W-1:0];
        pidaw_pkg::REG_DERIV_GAIN:   deriv_gain   <= cfg_data[GAIN_W-1:0];
        pidaw_pkg::REG_CLAMP_ENABLE: clamp_enable <= cfg_data[0];
        pidaw_pkg::REG_INTEG_LIMIT:  integ_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // integrator: clamp to +/- limit when enabled, then saturate to the accumulator width
  assign lim_pos = {{(SUM_W-LIMIT_W){1'b0}}, integ_limit};
  assign lim_neg = -lim_pos;

  always_comb begin
    sum_clamp = sum_q;
    if (clamp_enable) begin
      if (sum_q > lim_pos) begin
        sum_clamp = lim_pos;
      end else if (sum_q < lim_neg) begin
        sum_clamp = lim_neg;
      end
    end
    if (sum_clamp > ACC_MAX) begin
      sum_sat = ACC_MAX;
    end else if (sum_clamp < ACC_MIN) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = sum_clamp;
    end
  end

  // one multiplier, fed the signed upper half first and the unsigned lower half second
  assign mul_opnd = (state == S_MUL_HI) ? {mul_b[WIDE_W-1], mul_b[WIDE_W-1:SPLIT_W]}
                                        : {1'b0, mul_b[SPLIT_W-1:0]};
  assign mul_out  = mul_a * mul_opnd;
  assign fin      = {macc_hi, {SPLIT_W{1'b0}}} + {{SPLIT_W{prod[PROD_W-1]}}, prod};
  assign fin_sat  = pidaw_pkg::sat_out(fin);

  // derivative numerator, sign and magnitude for the divider
  assign num     = fin[NUM_W-1:0];
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // two restoring divide steps per cycle
  always_comb begin
    logic [TICK_W:0] trial;
    logic [TICK_W:0] diffr;
    rem_next = rem;
    dq_next  = dq;
    for (int k = 0; k < 2; k++) begin
      trial   = {rem_next, dq_next[DIV_W-1]};
      dq_next = {dq_next[DIV_W-2:0], 1'b0};
      diffr   = trial - {1'b0, ticks};
      if (trial >= {1'b0, ticks}) begin
        rem_next   = diffr[TICK_W-1:0];
        dq_next[0] = 1'b1;
      end else begin
        rem_next = trial[TICK_W-1:0];
      end
    end
  end

  assign quo_ext = div_neg ? -{{(MACC_W-DIV_W){1'b0}}, dq} : {{(MACC_W-DIV_W){1'b0}}, dq};

  assign drive_sum = {{(MACC_W-OUT_W){p_q[OUT_W-1]}}, p_q}
                   + {{(MACC_W-OUT_W){i_q[OUT_W-1]}}, i_q}
                   + {{(MACC_W-OUT_W){d_q[OUT_W-1]}}, d_q};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op         <= OP_P;
      out_valid  <= 1'b0;
      integ_acc  <= '0;
      prev_error <= '0;
      div_cnt    <= '0;
    end else begin
      // a taken result clears unless the final sum step reloads it in the same cycle
      if (out_valid && !out_stall && state != S_SUM) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            err   <= ERR_W'(setpoint) - ERR_W'(measured);
            ticks <= elapsed_ticks;
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          sum_q      <= {{(SUM_W-ACC_WIDTH){integ_acc[ACC_WIDTH-1]}}, integ_acc}
                      + {{(SUM_W-ERR_W){err[ERR_W-1]}}, err};
          diff       <= DIFF_W'(err) - DIFF_W'(prev_error);
          prev_error <= err;
          state      <= S_CLAMP;
        end
        S_CLAMP: begin
          integ_acc <= sum_sat[ACC_WIDTH-1:0];
          // proportional product first
          op    <= OP_P;
          mul_a <= MUL_A_W'(prop_gain);
          mul_b <= WIDE_W'(err);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod  <= mul_out;
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          macc_hi <= prod;
          prod    <= mul_out;
          state   <= S_MUL_END;
        end
        S_MUL_END: begin
          case (op)
            OP_P: begin
              p_q <= fin_sat;
              if (ticks == '0) begin
                // zero interval: integral and derivative terms vanish
                i_q   <= '0;
                d_q   <= '0;
                state <= S_SUM;
              end else begin
                op    <= OP_KI;
                mul_a <= MUL_A_W'(integ_gain);
                mul_b <= WIDE_W'(integ_acc);
                state <= S_MUL_HI;
              end
            end
            OP_KI: begin
              tprod <= fin_sat;
              op    <= OP_TK;
              mul_a <= {1'b0, ticks};
              mul_b <= fin_sat;
              state <= S_MUL_HI;
            end
            OP_TK: begin
              i_q   <= fin_sat;
              op    <= OP_KD;
              mul_a <= MUL_A_W'(deriv_gain);
              mul_b <= WIDE_W'(diff);
              state <= S_MUL_HI;
            end
            OP_KD: begin
              dq      <= DIV_W'(num_mag);
              rem     <= '0;
              div_neg <= num[NUM_W-1];
              div_cnt <= CNT_W'(DIV_STEPS - 1);
              state   <= S_DIV;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DIV: begin
          dq  <= dq_next;
          rem <= rem_next;
          if (div_cnt == '0) begin
            state <= S_DFIN;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_DFIN: begin
          // quotient truncated toward zero, sign restored
          d_q   <= pidaw_pkg::sat_out(quo_ext);
          state <= S_SUM;
        end
        S_SUM: begin
          // wait here while a previous result is still held in the output register
          if (out_free) begin
            drive     <= pidaw_pkg::sat_out(drive_sum);
            p_term    <= p_q;
            i_term    <= i_q;
            d_term    <= d_q;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // tprod is the saturated ki*integrator product fed back as the next wide operand
  logic tprod_fed;
  assign tprod_fed = (tprod == mul_b);

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_INTEG))
    else $error("accepted transaction did not start the integrator step");

  a_result_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SUM))
    else $error("result transaction raised outside the final sum step");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == '0) |=> (state == S_DFIN))
    else $error("divider did not finish after its last step");

  a_zero_ticks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && ticks == '0) |-> (i_q == '0 && d_q == '0))
    else $error("zero interval left a nonzero integral or derivative term");

  a_prev_error: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_INTEG) |-> (prev_error == err))
    else $error("previous error not updated after the integrator step");

  a_tk_operand: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_HI && op == OP_TK) |-> tprod_fed)
    else $error("ticks product started on the wrong operand");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking testbench for the pid core with integrator clamp
module tb;

  localparam int SW    = pidaw_pkg::SAMPLE_WIDTH_DEF;
  localparam int ACC_W = pidaw_pkg::ACC_WIDTH_DEF;

  // field and port widths
  localparam int OUT_W      = pidaw_pkg::OUT_W;
  localparam int GAIN_W     = pidaw_pkg::GAIN_W;
  localparam int LIMIT_W    = pidaw_pkg::LIMIT_W;
  localparam int TICK_W     = pidaw_pkg::TICK_W;
  localparam int CFG_IDX_W  = pidaw_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pidaw_pkg::CFG_DATA_W;

  // saturation bounds of the result fields and of the integrator
  localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;
  localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  // register indexes past the end of the register list, written only to be ignored
  localparam int LAST_REG_INDEX = (1 << CFG_IDX_W) - 1;

  // named gain settings of the directed table
  localparam logic [3:0] SET_NEG_KP   = 4'd0;
  localparam logic [3:0] SET_WIDE     = 4'd1;
  localparam logic [3:0] SET_FLIPPED  = 4'd2;
  localparam logic [3:0] SET_TIGHT    = 4'd3;
  localparam logic [3:0] KEEP_SETTING = 4'hf;
  localparam int NUM_DIRECTED = 20;

  // random part shape
  localparam int NUM_PHASES    = 8;
  localparam int QUIET_PHASE   = 0;
  localparam int WINDUP_PHASE  = 2;
  localparam int HOLD_PHASE    = 4;
  localparam int PAUSE_PHASE   = 6;
  localparam int PHASE_ITEMS   = 42;
  localparam int WINDUP_ITEMS  = 160;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 20;

  typedef struct packed {
    logic signed [OUT_W-1:0] ctl;
    logic signed [OUT_W-1:0] prop;
    logic signed [OUT_W-1:0] integ;
    logic signed [OUT_W-1:0] deriv;
  } pid_out_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic                      clamp;
    logic        [LIMIT_W-1:0] limit;
  } gain_set_t;

  typedef struct packed {
    logic        [3:0]        setting;
    logic signed [SW-1:0]     meas;
    logic signed [SW-1:0]     sp;
    logic        [TICK_W-1:0] ticks;
    logic                     typed;
    pid_out_t                 want;
  } vector_row_t;

  localparam pid_out_t ZERO_OUT = '0;

  // dut ports
  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [SW-1:0]     measured;
  logic signed [SW-1:0]     setpoint;
  logic [TICK_W-1:0]        elapsed_ticks;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [OUT_W-1:0]  drive;
  logic signed [OUT_W-1:0]  p_term;
  logic signed [OUT_W-1:0]  i_term;
  logic signed [OUT_W-1:0]  d_term;

  // predictor copy of the registers and the loop state
  logic signed [GAIN_W-1:0] prop_gain_m;
  logic signed [GAIN_W-1:0] integ_gain_m;
  logic signed [GAIN_W-1:0] deriv_gain_m;
  logic                     clamp_m;
  logic [LIMIT_W-1:0]       limit_m;
  logic signed [ACC_W-1:0]  integ_state;
  logic signed [SW:0]       prev_err;

  // results still owed by the dut, oldest first
  pid_out_t expected_results[$];
  pid_out_t oldest;

  gain_set_t   gain_sets [0:3];
  vector_row_t directed_rows [0:NUM_DIRECTED-1];

  int  mismatch_count;
  int  results_seen;
  int  items_sent;
  int  settings_used;
  int  zero_tick_items;
  int  saturated_terms;
  bit  tx_quiet;
  bit  rx_quiet;
  int  hold_req;

  pid_controller_anti_windup_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .measured      (measured),
    .setpoint      (setpoint),
    .elapsed_ticks (elapsed_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive         (drive),
    .p_term        (p_term),
    .i_term        (i_term),
    .d_term        (d_term)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results still owed", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // saturate to the 48-bit result range
  function automatic logic signed [OUT_W-1:0] clip48(input longint v);
    if (v > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    return OUT_W'(v);
  endfunction

  // one control step: updates integrator and previous error, returns the four outputs
  function automatic pid_out_t predict_control_output(input logic signed [SW-1:0] meas,
                                                      input logic signed [SW-1:0] sp,
                                                      input logic [TICK_W-1:0] ticks);
    longint err;
    longint sum;
    longint lim;
    longint scaled;
    longint n;
    logic signed [OUT_W-1:0] p_v;
    logic signed [OUT_W-1:0] i_v;
    logic signed [OUT_W-1:0] d_v;
    pid_out_t r;
    err = longint'(sp) - longint'(meas);
    sum = longint'(integ_state) + err;
    // anti-windup clamp, then the integrator's own width
    if (clamp_m) begin
      lim = longint'(limit_m);
      if (sum > lim) begin
        sum = lim;
      end else if (sum < -lim) begin
        sum = -lim;
      end
    end
    if (sum > ACC_MAX) begin
      sum = ACC_MAX;
    end else if (sum < ACC_MIN) begin
      sum = ACC_MIN;
    end
    integ_state = ACC_W'(sum);
    p_v = clip48(longint'(prop_gain_m) * err);
    n = longint'(ticks);
    if (n == 0) begin
      // zero interval: no integral and no derivative contribution
      i_v = '0;
      d_v = '0;
    end else begin
      scaled = longint'(clip48(longint'(integ_gain_m) * longint'(integ_state)));
      i_v = clip48(scaled * n);
      // signed division truncates toward zero
      d_v = clip48((longint'(deriv_gain_m) * (err - longint'(prev_err))) / n);
    end
    if (i_v == OUT_W'(OUT_MAX) || i_v == OUT_W'(OUT_MIN)) begin
      saturated_terms++;
    end
    r.prop  = p_v;
    r.integ = i_v;
    r.deriv = d_v;
    r.ctl   = clip48(longint'(p_v) + longint'(i_v) + longint'(d_v));
    prev_err = (SW + 1)'(err);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch on %s at result %0d: got %0d, want %0d",
               what, results_seen, $signed(got), $signed(want));
    end
  endtask

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (tx_quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(GAIN_W-1){1'b0}}};
      1: return {1'b0, {(GAIN_W-1){1'b1}}};
      2: return '0;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return LIMIT_W'($urandom_range(1, 300));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return {1'b1, {(SW-1){1'b0}}};
      1: return {1'b0, {(SW-1){1'b1}}};
      2: return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TICK_W'(1);
      2: return '1;
      3, 4, 5: return TICK_W'($urandom_range(1, 16));
      default: return TICK_W'($urandom);
    endcase
  endfunction

  // stop offering and wait until every owed result is back, plus the latency
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    // bits above a register's width are dropped
    case (idx)
      pidaw_pkg::REG_PROP_GAIN:    prop_gain_m  = data[GAIN_W-1:0];
      pidaw_pkg::REG_INTEG_GAIN:   integ_gain_m = data[GAIN_W-1:0];
      pidaw_pkg::REG_DERIV_GAIN:   deriv_gain_m = data[GAIN_W-1:0];
      pidaw_pkg::REG_CLAMP_ENABLE: clamp_m      = data[0];
      pidaw_pkg::REG_INTEG_LIMIT:  limit_m      = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // load a gain setting while the core is idle; junk goes to the unused indexes
  task automatic apply_gains(input gain_set_t g);
    drain_results();
    write_reg(pidaw_pkg::REG_PROP_GAIN,    {(CFG_DATA_W-GAIN_W)'($urandom), g.kp});
    write_reg(pidaw_pkg::REG_INTEG_GAIN,   {(CFG_DATA_W-GAIN_W)'($urandom), g.ki});
    write_reg(pidaw_pkg::REG_DERIV_GAIN,   {(CFG_DATA_W-GAIN_W)'($urandom), g.kd});
    write_reg(pidaw_pkg::REG_CLAMP_ENABLE, {(CFG_DATA_W-1)'($urandom), g.clamp});
    write_reg(pidaw_pkg::REG_INTEG_LIMIT,  g.limit);
    for (int k = pidaw_pkg::REG_INTEG_LIMIT + 1; k <= LAST_REG_INDEX; k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // offer one transaction, hold it until taken, then log what it should produce
  task automatic send_item(input logic signed [SW-1:0] meas, input logic signed [SW-1:0] sp,
                           input logic [TICK_W-1:0] ticks, input logic typed,
                           input pid_out_t typed_out);
    int gap;
    pid_out_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    measured      <= meas;
    setpoint      <= sp;
    elapsed_ticks <= ticks;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = predict_control_output(meas, sp, ticks);
    expected_results.push_back(typed ? typed_out : predicted);
    items_sent++;
    if (ticks == 0) begin
      zero_tick_items++;
    end
  endtask

  // receiver: random stalls, quiet stretches and one long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_quiet || $urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  // result checker: every taken result against the oldest owed one
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none owed (drive)", drive, '0);
      end else begin
        oldest = expected_results.pop_front();
        if (drive !== oldest.ctl) begin
          report_mismatch("drive", drive, oldest.ctl);
        end
        if (p_term !== oldest.prop) begin
          report_mismatch("p_term", p_term, oldest.prop);
        end
        if (i_term !== oldest.integ) begin
          report_mismatch("i_term", i_term, oldest.integ);
        end
        if (d_term !== oldest.deriv) begin
          report_mismatch("d_term", d_term, oldest.deriv);
        end
      end
    end
  end

  // stimulus
  initial begin
    gain_set_t g;
    logic signed [SW-1:0] meas_r;
    logic signed [SW-1:0] sp_r;
    int phase_len;
    bit push_up;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    measured      = '0;
    setpoint      = '0;
    elapsed_ticks = '0;
    prop_gain_m   = '0;
    integ_gain_m  = '0;
    deriv_gain_m  = '0;
    clamp_m       = 1'b0;
    limit_m       = '0;
    integ_state   = '0;
    prev_err      = '0;
    mismatch_count  = 0;
    results_seen    = 0;
    items_sent      = 0;
    settings_used   = 0;
    zero_tick_items = 0;
    saturated_terms = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    hold_req = 0;

    // kp, ki, kd, clamp, limit
    gain_sets[SET_NEG_KP[1:0]]  = '{16'sh8000, 16'sh0000, 16'sh0000, 1'b1, 23'd0};
    gain_sets[SET_WIDE[1:0]]    = '{16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, 23'h7fffff};
    gain_sets[SET_FLIPPED[1:0]] = '{16'shffff, 16'sh8000, 16'sh7fff, 1'b1, 23'h7fffff};
    gain_sets[SET_TIGHT[1:0]]   = '{16'sd256, 16'sd1, 16'shff00, 1'b1, 23'd100};

    // setting, measured, setpoint, ticks, typed, expected {drive, p, i, d}
    directed_rows = '{
      // after reset all gains are zero
      '{KEEP_SETTING, 16'sh8000, 16'sh7fff, 16'hffff, 1'b1, ZERO_OUT},
      '{KEEP_SETTING, 16'sh7fff, 16'sh8000, 16'h0000, 1'b1, ZERO_OUT},
      // most negative kp on the widest errors, clamp on with zero limit
      '{SET_NEG_KP, 16'sh8000, 16'sh7fff, 16'h0000, 1'b1,
        '{-48'sd2147450880, -48'sd2147450880, 48'sd0, 48'sd0}},
      '{KEEP_SETTING, 16'sh7fff, 16'sh8000, 16'hffff, 1'b1,
        '{48'sd2147450880, 48'sd2147450880, 48'sd0, 48'sd0}},
      '{KEEP_SETTING, 16'sh0000, 16'sh0000, 16'h0001, 1'b1, ZERO_OUT},
      // clamp off, largest gains: integral product overflows 48 bits
      '{SET_WIDE, 16'sh8000, 16'sh7fff, 16'hffff, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh8000, 16'sh7fff, 16'hffff, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh8000, 16'sh7fff, 16'hffff, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh7fff, 16'sh8000, 16'h0001, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh0000, 16'sh0000, 16'h0000, 1'b0, ZERO_OUT},
      // limit at the top of the integrator range, negative integral gain
      '{SET_FLIPPED, -16'sd100, 16'sd100, 16'h0001, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh7fff, 16'sh8000, 16'hffff, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh7fff, 16'sh8000, 16'h0000, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh0000, -16'sd7, 16'h0003, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b0, ZERO_OUT},
      // small limit: integrator pinned at both bounds
      '{SET_TIGHT, 16'sh0000, 16'sd1000, 16'h0005, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh0000, 16'sd1000, 16'h0005, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh7fff, 16'sh8000, 16'h0007, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sd1, 16'sh0000, 16'hffff, 1'b0, ZERO_OUT},
      '{KEEP_SETTING, 16'sh0000, -16'sd1, 16'h0009, 1'b0, ZERO_OUT}
    };

    // synchronous reset, held at the start and then released
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[n]) begin
      if (directed_rows[n].setting != KEEP_SETTING) begin
        apply_gains(gain_sets[directed_rows[n].setting[1:0]]);
      end
      send_item(directed_rows[n].meas, directed_rows[n].sp, directed_rows[n].ticks,
                directed_rows[n].typed, directed_rows[n].want);
    end

    // random phases, each under a fresh gain setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      g.kp    = pick_gain();
      g.ki    = pick_gain();
      g.kd    = pick_gain();
      g.clamp = 1'($urandom_range(0, 1));
      g.limit = pick_limit();
      if (phase == WINDUP_PHASE) begin
        g.clamp = 1'b0;
      end
      apply_gains(g);
      tx_quiet  = (phase == QUIET_PHASE);
      rx_quiet  = (phase == QUIET_PHASE);
      phase_len = (phase == WINDUP_PHASE) ? WINDUP_ITEMS : PHASE_ITEMS;
      // receiver holds off while the sender keeps offering, so the input backs up
      if (phase == HOLD_PHASE) begin
        hold_req = HOLD_CYCLES;
      end
      // windup pushes the error the way the integrator already leans, until it saturates
      push_up = (integ_state >= 0);
      for (int n = 0; n < phase_len; n++) begin
        if (phase == PAUSE_PHASE && n == phase_len / 2) begin
          drain_results();
        end
        if (phase == WINDUP_PHASE && $urandom_range(0, 9) != 0) begin
          if (push_up) begin
            sp_r   = SW'(32767 - $urandom_range(0, 300));
            meas_r = SW'(-32768 + $urandom_range(0, 300));
          end else begin
            sp_r   = SW'(-32768 + $urandom_range(0, 300));
            meas_r = SW'(32767 - $urandom_range(0, 300));
          end
        end else begin
          sp_r   = pick_sample();
          meas_r = pick_sample();
        end
        send_item(meas_r, sp_r, pick_ticks(), 1'b0, ZERO_OUT);
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // everything owed must come back
    drain_results();

    $display("sent %0d transactions under %0d gain settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("  %0d with zero interval, %0d with a saturated integral term, %0d mismatches",
             zero_tick_items, saturated_terms, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: pid_controller_anti_windup_core.f
rtl/pidaw_pkg.sv
rtl/pid_controller_anti_windup_core.sv
verif/tb.sv
